@@ hw/rtl/mwmff_pkg.sv @@
// shared types, constants and cell helpers for the maze map flood fill block
package mwmff_pkg;

    localparam int MAZE_SIDE   = 16;
    localparam int QUEUE_DEPTH = 256;
    localparam int CELLS       = MAZE_SIDE * MAZE_SIDE;
    localparam int CRD_W       = $clog2(MAZE_SIDE);
    localparam int CELL_W      = 2 * CRD_W;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIST_W      = 8;
    localparam int WALL_W      = 5;

    localparam logic [DIST_W-1:0] UNREACHED   = 8'hFF;
    localparam logic [3:0]        WALL_BITS   = 4'hF;
    localparam logic [WALL_W-1:0] VISITED_BIT = 5'h10;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_WALLS  = 3'd1,
        ACT_VISIT  = 3'd2,
        ACT_FGOAL  = 3'd3,
        ACT_FTGT   = 3'd4,
        ACT_BEST   = 3'd5,
        ACT_READ   = 3'd6,
        ACT_NOP    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        CFG_GXL = 2'd0,
        CFG_GXH = 2'd1,
        CFG_GYL = 2'd2,
        CFG_GYH = 2'd3
    } cfg_reg_t;

    // neighbor in direction d lies inside the maze
    function automatic logic nb_ok(logic [CELL_W-1:0] c, logic [1:0] d);
        logic ok;
        unique case (dir_t'(d))
            DIR_N: ok = c[CELL_W-1:CRD_W] != CRD_W'(MAZE_SIDE - 1);
            DIR_E: ok = c[CRD_W-1:0] != CRD_W'(MAZE_SIDE - 1);
            DIR_S: ok = c[CELL_W-1:CRD_W] != '0;
            default: ok = c[CRD_W-1:0] != '0;
        endcase
        return ok;
    endfunction

    function automatic logic [CELL_W-1:0] nb_addr(logic [CELL_W-1:0] c, logic [1:0] d);
        logic [CELL_W-1:0] n;
        unique case (dir_t'(d))
            DIR_N: n = {c[CELL_W-1:CRD_W] + CRD_W'(1), c[CRD_W-1:0]};
            DIR_E: n = {c[CELL_W-1:CRD_W], c[CRD_W-1:0] + CRD_W'(1)};
            DIR_S: n = {c[CELL_W-1:CRD_W] - CRD_W'(1), c[CRD_W-1:0]};
            default: n = {c[CELL_W-1:CRD_W], c[CRD_W-1:0] - CRD_W'(1)};
        endcase
        return n;
    endfunction

    // wall word of a cell right after a clear
    function automatic logic [WALL_W-1:0] boundary(logic [CELL_W-1:0] c);
        logic [WALL_W-1:0] w;
        w = '0;
        w[DIR_N] = c[CELL_W-1:CRD_W] == CRD_W'(MAZE_SIDE - 1);
        w[DIR_E] = c[CRD_W-1:0] == CRD_W'(MAZE_SIDE - 1);
        w[DIR_S] = c[CELL_W-1:CRD_W] == '0;
        w[DIR_W] = c[CRD_W-1:0] == '0;
        return w;
    endfunction

endpackage

@@ hw/rtl/maze_wall_map_flood_fill_top.sv @@
// maze wall map with breadth-first flood fill over on-chip cell memories
// a flood first sweeps every distance to unreached, then seeds the goal cells
// (or the target cell) at distance zero, then dequeues cells and relaxes
// their open neighbors
// throughput: one item at a time; input is taken only in the idle state
// reset: a clearing pass writes boundary walls and distances; no item
// is taken during it, configuration writes are
module maze_wall_map_flood_fill_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_x, cell_y, heading, wall_front, wall_left, wall_right
    input  logic [2:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cell_walls, visited, cell_distance, best_heading, at_goal
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int CW = mwmff_pkg::CELL_W;
    localparam int XW = mwmff_pkg::CRD_W;
    localparam int DW = mwmff_pkg::DIST_W;
    localparam int WW = mwmff_pkg::WALL_W;
    localparam int QW = mwmff_pkg::QPTR_W;

    typedef enum logic [10:0] {
        ST_CLR  = 11'b000_0000_0001,
        ST_IDLE = 11'b000_0000_0010,
        ST_WRD  = 11'b000_0000_0100,
        ST_WWB  = 11'b000_0000_1000,
        ST_SEED = 11'b000_0001_0000,
        ST_QRD  = 11'b000_0010_0000,
        ST_CRD  = 11'b000_0100_0000,
        ST_NB   = 11'b000_1000_0000,
        ST_RRD  = 11'b001_0000_0000,
        ST_RES  = 11'b010_0000_0000,
        ST_SPARE = 11'b100_0000_0000
    } state_t;

    state_t state_reg;

    logic [WW-1:0] wall_mem [mwmff_pkg::CELLS];
    logic [DW-1:0] dist_mem [mwmff_pkg::CELLS];
    logic [CW-1:0] q_mem    [mwmff_pkg::QUEUE_DEPTH];

    logic          wall_we, wall_re, dist_we, dist_re, q_we, q_re;
    logic [CW-1:0] wall_waddr, wall_raddr, dist_waddr, dist_raddr;
    logic [WW-1:0] wall_wdata, wall_rd_reg;
    logic [DW-1:0] dist_wdata, dist_rd_reg;
    logic [QW-1:0] q_raddr;
    logic [CW-1:0] q_wdata, q_rd_reg;

    logic [XW-1:0] gxl_reg, gxh_reg, gyl_reg, gyh_reg;

    logic [2:0]    act_reg;
    logic [CW-1:0] cell_reg, c_reg, w_addr_reg, nprev_reg;
    logic [1:0]    head_reg, best_reg;
    logic [3:0]    setd_reg;
    logic [WW-1:0] w_mask_reg;
    logic [2:0]    j_reg, k_reg;
    logic [CW:0]   swp_reg;
    logic          clr_walls_reg, clr_idle_reg, walk_reg, tgt_reg, vld_reg;
    logic [XW:0]   gx_reg, gy_reg;
    logic [DW:0]   nd_reg;
    logic [DW-1:0] mind_reg;
    logic [QW-1:0] qhead_reg, qtail_reg;
    logic [QW:0]   qcnt_reg;
    logic          m_valid_reg;
    logic [15:0]   m_data_reg;

    logic          s_acc, rect_ok, seed_go, w_skip, upd, q_room;
    logic [CW-1:0] seed_addr, w_addr, crd_addr;
    logic [WW-1:0] w_mask;
    logic [1:0]    wd;
    logic [3:0]    setd;
    logic [2:0]    in_act;
    logic [1:0]    in_head;
    logic          at_goal;

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign in_act    = s_tuser;
    assign in_head   = s_tdata[9:8];

    always_comb begin
        setd = '0;
        if (s_tdata[10]) setd[in_head] = 1'b1;
        if (s_tdata[11]) setd[in_head + 2'd3] = 1'b1;
        if (s_tdata[12]) setd[in_head + 2'd1] = 1'b1;
    end

    assign rect_ok   = (gxl_reg <= gxh_reg) && (gyl_reg <= gyh_reg);
    assign seed_addr = tgt_reg ? cell_reg : {gy_reg[XW-1:0], gx_reg[XW-1:0]};
    assign seed_go   = tgt_reg || (rect_ok && gx_reg <= {1'b0, gxh_reg});
    assign q_room    = qcnt_reg < (QW+1)'(mwmff_pkg::QUEUE_DEPTH);
    assign crd_addr  = walk_reg ? q_rd_reg : cell_reg;
    assign wd        = 2'(j_reg - 3'd1);

    // wall update step: the cell itself first, then each neighbor across a new wall
    always_comb begin
        if (j_reg == 3'd0) begin
            w_addr = cell_reg;
            w_skip = 1'b0;
            w_mask = (act_reg == mwmff_pkg::ACT_VISIT) ? mwmff_pkg::VISITED_BIT
                                                        : {1'b0, setd_reg};
        end else begin
            w_addr = mwmff_pkg::nb_addr(cell_reg, wd);
            w_skip = !(setd_reg[wd] && mwmff_pkg::nb_ok(cell_reg, wd));
            w_mask = '0;
            w_mask[wd + 2'd2] = 1'b1;
        end
    end

    assign upd = (k_reg != 3'd0) && vld_reg && walk_reg && (nd_reg < {1'b0, dist_rd_reg});

    assign at_goal = cell_reg[XW-1:0] >= gxl_reg && cell_reg[XW-1:0] <= gxh_reg &&
                     cell_reg[CW-1:XW] >= gyl_reg && cell_reg[CW-1:XW] <= gyh_reg;

    always_comb begin
        wall_we = 1'b0; wall_waddr = w_addr_reg; wall_wdata = wall_rd_reg | w_mask_reg;
        wall_re = 1'b0; wall_raddr = cell_reg;
        dist_we = 1'b0; dist_waddr = nprev_reg; dist_wdata = nd_reg[DW-1:0];
        dist_re = 1'b0; dist_raddr = cell_reg;
        q_we = 1'b0; q_wdata = nprev_reg;
        q_re = 1'b0; q_raddr = qhead_reg;
        unique case (state_reg)
            ST_CLR: begin
                wall_we    = clr_walls_reg;
                wall_waddr = swp_reg[CW-1:0];
                wall_wdata = mwmff_pkg::boundary(swp_reg[CW-1:0]);
                dist_we    = 1'b1;
                dist_waddr = swp_reg[CW-1:0];
                dist_wdata = mwmff_pkg::UNREACHED;
            end
            ST_WRD: begin
                wall_re    = !w_skip;
                wall_raddr = w_addr;
            end
            ST_WWB: wall_we = 1'b1;
            ST_SEED: begin
                dist_we    = seed_go;
                dist_waddr = seed_addr;
                dist_wdata = '0;
                q_we       = seed_go && q_room;
                q_wdata    = seed_addr;
            end
            ST_QRD: q_re = qcnt_reg != '0;
            ST_CRD: begin
                wall_re    = 1'b1;
                wall_raddr = crd_addr;
                dist_re    = 1'b1;
                dist_raddr = crd_addr;
            end
            ST_NB: begin
                dist_re    = k_reg != 3'd4;
                dist_raddr = mwmff_pkg::nb_addr(c_reg, k_reg[1:0]);
                dist_we    = upd;
                q_we       = upd && q_room;
            end
            ST_RRD: begin
                wall_re = 1'b1;
                dist_re = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
        if (wall_re) wall_rd_reg <= wall_mem[wall_raddr];
        if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
        if (dist_re) dist_rd_reg <= dist_mem[dist_raddr];
        if (q_we) q_mem[qtail_reg] <= q_wdata;
        if (q_re) q_rd_reg <= q_mem[q_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gxl_reg <= 4'd7;
            gxh_reg <= 4'd8;
            gyl_reg <= 4'd7;
            gyh_reg <= 4'd8;
        end else if (cfg_valid && cfg_ready && cfg_index[3:2] == 2'b00) begin
            unique case (mwmff_pkg::cfg_reg_t'(cfg_index[1:0]))
                mwmff_pkg::CFG_GXL: gxl_reg <= cfg_data;
                mwmff_pkg::CFG_GXH: gxh_reg <= cfg_data;
                mwmff_pkg::CFG_GYL: gyl_reg <= cfg_data;
                default:            gyh_reg <= cfg_data;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            act_reg  <= in_act;
            cell_reg <= {s_tdata[7:4], s_tdata[3:0]};
            head_reg <= in_head;
            setd_reg <= (in_act == mwmff_pkg::ACT_WALLS) ? setd : 4'd0;
            j_reg    <= '0;
            gx_reg   <= {1'b0, gxl_reg};
            gy_reg   <= {1'b0, gyl_reg};
            tgt_reg  <= in_act == mwmff_pkg::ACT_FTGT;
            walk_reg <= in_act != mwmff_pkg::ACT_BEST;
            c_reg    <= {s_tdata[7:4], s_tdata[3:0]};
        end
        if (state_reg == ST_WRD && !w_skip) begin
            w_addr_reg <= w_addr;
            w_mask_reg <= w_mask;
        end
        if ((state_reg == ST_WRD && w_skip) || state_reg == ST_WWB) j_reg <= j_reg + 3'd1;
        if (state_reg == ST_SEED && !tgt_reg) begin
            if (gy_reg >= {1'b0, gyh_reg}) begin
                gy_reg <= {1'b0, gyl_reg};
                gx_reg <= gx_reg + (XW+1)'(1);
            end else begin
                gy_reg <= gy_reg + (XW+1)'(1);
            end
        end
        if (state_reg == ST_CRD) begin
            c_reg <= crd_addr;
            k_reg <= '0;
        end
        if (state_reg == ST_NB) begin
            k_reg <= k_reg + 3'd1;
            if (k_reg == 3'd0) begin
                nd_reg   <= {1'b0, dist_rd_reg} + (DW+1)'(1);
                mind_reg <= mwmff_pkg::UNREACHED;
                best_reg <= head_reg;
            end else if (vld_reg && !walk_reg && dist_rd_reg < mind_reg) begin
                mind_reg <= dist_rd_reg;
                best_reg <= 2'(k_reg - 3'd1);
            end
            if (k_reg != 3'd4) begin
                vld_reg   <= !wall_rd_reg[k_reg[1:0]] && mwmff_pkg::nb_ok(c_reg, k_reg[1:0]);
                nprev_reg <= mwmff_pkg::nb_addr(c_reg, k_reg[1:0]);
            end
        end
        if (state_reg == ST_RES && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {at_goal,
                           (act_reg == mwmff_pkg::ACT_BEST) ? best_reg : 2'd0,
                           dist_rd_reg, wall_rd_reg[4], wall_rd_reg[3:0]};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            swp_reg       <= '0;
            clr_walls_reg <= 1'b1;
            clr_idle_reg  <= 1'b1;
            qhead_reg     <= '0;
            qtail_reg     <= '0;
            qcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_RES) m_valid_reg <= 1'b0;
            if (q_we) begin
                qtail_reg <= qtail_reg + QW'(1);
                qcnt_reg  <= qcnt_reg + (QW+1)'(1);
            end
            unique case (state_reg)
                ST_CLR: begin
                    if (swp_reg[CW-1:0] == '1) begin
                        swp_reg   <= '0;
                        qhead_reg <= '0;
                        qtail_reg <= '0;
                        qcnt_reg  <= '0;
                        if (clr_idle_reg) state_reg <= ST_IDLE;
                        else if (clr_walls_reg) state_reg <= ST_RRD;
                        else state_reg <= ST_SEED;
                    end else begin
                        swp_reg <= swp_reg + (CW+1)'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        clr_idle_reg <= 1'b0;
                        unique case (mwmff_pkg::action_t'(in_act))
                            mwmff_pkg::ACT_CLEAR: begin
                                clr_walls_reg <= 1'b1;
                                state_reg     <= ST_CLR;
                            end
                            mwmff_pkg::ACT_WALLS,
                            mwmff_pkg::ACT_VISIT: state_reg <= ST_WRD;
                            mwmff_pkg::ACT_FGOAL,
                            mwmff_pkg::ACT_FTGT: begin
                                clr_walls_reg <= 1'b0;
                                state_reg     <= ST_CLR;
                            end
                            mwmff_pkg::ACT_BEST: state_reg <= ST_CRD;
                            default: state_reg <= ST_RRD;
                        endcase
                    end
                end
                ST_WRD: begin
                    if (!w_skip) state_reg <= ST_WWB;
                    else if (j_reg == 3'd4) state_reg <= ST_RRD;
                end
                ST_WWB: state_reg <= (j_reg == 3'd4) ? ST_RRD : ST_WRD;
                ST_SEED: begin
                    if (tgt_reg || !seed_go) state_reg <= ST_QRD;
                end
                ST_QRD: begin
                    if (qcnt_reg == '0) begin
                        state_reg <= ST_RRD;
                    end else begin
                        qhead_reg <= qhead_reg + QW'(1);
                        qcnt_reg  <= qcnt_reg - (QW+1)'(1);
                        state_reg <= ST_CRD;
                    end
                end
                ST_CRD: state_reg <= ST_NB;
                ST_NB: begin
                    if (k_reg == 3'd4) state_reg <= walk_reg ? ST_QRD : ST_RRD;
                end
                ST_RRD: state_reg <= ST_RES;
                ST_RES: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/mwmff_checker.sv @@
// port-level checks for the maze map flood fill block
module mwmff_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a result that is not taken stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // only one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block ready right after reset");

    // an offered result always carries a known best heading and goal flag
    a_bits_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown(m_tdata[15:13]))
        else $error("unknown best heading or goal flag");

endmodule

bind maze_wall_map_flood_fill_top mwmff_checker u_mwmff_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
